### hw/rtl/dsfp_pkg.sv
// Package for the DAC sample FIFO pacer: sizes, reset values, function codes,
// the result struct and pointer helpers. Depends on nothing.
package dsfp_pkg;

  localparam int unsigned FifoDepth = 128;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam int unsigned EntryW    = 16;
  localparam int unsigned SampleW   = 12;
  localparam int unsigned LedW      = 4;
  localparam int unsigned TickW     = 8;
  localparam int unsigned LevelW    = 8;

  localparam logic [TickW-1:0]  TicksReset = 8'd4;
  localparam logic [TickW-1:0]  LedCount   = 8'd2;
  localparam logic [EntryW-1:0] DacCmdFlag = 16'h1000;
  localparam logic [CntW-1:0]   FullCount  = CntW'(FifoDepth);
  localparam logic [PtrW-1:0]   LastPtr    = PtrW'(FifoDepth - 1);

  typedef enum logic [1:0] {
    FuncTick  = 2'd0,
    FuncPush  = 2'd1,
    FuncFlush = 2'd2
  } func_e;

  typedef struct packed {
    logic               dac_valid;
    logic [EntryW-1:0]  dac_word;
    logic               led_valid;
    logic [LedW-1:0]    led_value;
    logic [LevelW-1:0]  fill_level;
    logic               push_accepted;
  } result_t;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == LastPtr) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

  function automatic logic [LevelW-1:0] to_level(input logic [CntW-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[LevelW-1:0];
  endfunction

endpackage

### hw/rtl/dsfp_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module dsfp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dsfp_core.sv
// FIFO pointers, fill count, tick counter, rate register and head prefetch.
// Uses dsfp_pkg and dsfp_ram.
module dsfp_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dsfp_pkg::TickW-1:0]         cfg_wdata_i,
  input  logic                               accept_i,
  input  logic [1:0]                         func_i,
  input  logic [dsfp_pkg::SampleW-1:0]       sample_value_i,
  input  logic [dsfp_pkg::LedW-1:0]          led_pattern_i,
  input  logic                               playing_i,
  input  logic                               standby_i,
  output dsfp_pkg::result_t                  result_o
);

  logic [dsfp_pkg::PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [dsfp_pkg::CntW-1:0]   fill_q, fill_d;
  logic [dsfp_pkg::TickW-1:0]  cnt_q, cnt_d, cnt_dec;
  logic [dsfp_pkg::TickW-1:0]  ticks_q;
  logic [dsfp_pkg::FifoDepth-1:0] valid_q;
  logic                        fwd_hit_q, fwd_hit_d;
  logic [dsfp_pkg::EntryW-1:0] fwd_data_q, wdata, ram_rdata, head_raw, head;
  logic                        ram_we;
  dsfp_pkg::func_e             func;
  dsfp_pkg::result_t           res;

  assign func  = dsfp_pkg::func_e'(func_i);
  assign wdata = {led_pattern_i, sample_value_i};

  dsfp_ram #(
    .Width (dsfp_pkg::EntryW),
    .Depth (dsfp_pkg::FifoDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (wdata),
    .raddr_i (rd_d),
    .rdata_o (ram_rdata)
  );

  // Head entry: forwarded write wins, never-written entries read as zero.
  assign head_raw = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign head     = valid_q[rd_q] ? head_raw : '0;
  assign cnt_dec  = cnt_q - dsfp_pkg::TickW'(1);

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    ram_we = 1'b0;
    res    = '0;
    if (accept_i) begin
      unique case (func)
        dsfp_pkg::FuncTick: begin
          cnt_d = cnt_dec;
          if (playing_i && !standby_i) begin
            if (cnt_dec == dsfp_pkg::LedCount) begin
              res.led_valid = 1'b1;
              res.led_value = head[dsfp_pkg::EntryW-1 -: dsfp_pkg::LedW];
            end
            if (cnt_dec == '0) begin
              cnt_d = ticks_q;
              if (fill_q != '0) begin
                res.dac_valid = 1'b1;
                res.dac_word  = dsfp_pkg::EntryW'(head[dsfp_pkg::SampleW-1:0])
                                | dsfp_pkg::DacCmdFlag;
                rd_d   = dsfp_pkg::next_ptr(rd_q);
                fill_d = fill_q - dsfp_pkg::CntW'(1);
              end
            end
          end
        end
        dsfp_pkg::FuncPush: begin
          if (fill_q != dsfp_pkg::FullCount) begin
            ram_we            = 1'b1;
            wr_d              = dsfp_pkg::next_ptr(wr_q);
            fill_d            = fill_q + dsfp_pkg::CntW'(1);
            res.push_accepted = 1'b1;
          end
        end
        dsfp_pkg::FuncFlush: begin
          wr_d   = '0;
          rd_d   = '0;
          fill_d = '0;
        end
        default: begin
        end
      endcase
    end
    res.fill_level = dsfp_pkg::to_level(fill_d);
  end

  // The RAM reads the next head address; bypass a write landing on it.
  assign fwd_hit_d = ram_we && (wr_q == rd_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      rd_q      <= '0;
      fill_q    <= '0;
      cnt_q     <= dsfp_pkg::TicksReset;
      ticks_q   <= dsfp_pkg::TicksReset;
      valid_q   <= '0;
      fwd_hit_q <= 1'b0;
    end else begin
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      fwd_hit_q <= fwd_hit_d;
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        valid_q[wr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata;
  end

  assign result_o = res;

endmodule

### hw/rtl/dsfp_out_skid.sv
// Result register with a skid stage, so the input side never waits on a
// same-cycle output stall. Uses dsfp_pkg.
module dsfp_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dsfp_pkg::result_t result_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dsfp_pkg::result_t result_o
);

  logic              out_valid_q, skid_valid_q, out_free;
  dsfp_pkg::result_t out_q, skid_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : result_i;
    end else if (push_i) begin
      skid_q <= result_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

### hw/rtl/dac_sample_fifo_pacer_top.sv
// DAC sample FIFO pacer top level: core state update feeding a skid-buffered result.
// The result lands in the output register, or in the skid stage behind a stalled output.
// Throughput: one item per cycle, set by the single-pass core update and head prefetch.
// Input stalls only while the skid stage holds a result behind a stalled output.
// Reset: pointers, fill count and entry valid bits clear at once; counter and rate
// reload to 4; no clearing pass over the sample store. Uses dsfp_pkg and submodules.
module dac_sample_fifo_pacer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // rate register write
  input  logic                          cfg_we_i,
  input  logic [dsfp_pkg::TickW-1:0]    cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [dsfp_pkg::SampleW-1:0]  sample_value_i,
  input  logic [dsfp_pkg::LedW-1:0]     led_pattern_i,
  input  logic                          playing_i,
  input  logic                          standby_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          dac_valid_o,
  output logic [dsfp_pkg::EntryW-1:0]   dac_word_o,
  output logic                          led_valid_o,
  output logic [dsfp_pkg::LedW-1:0]     led_value_o,
  output logic [dsfp_pkg::LevelW-1:0]   fill_level_o,
  output logic                          push_accepted_o
);

  logic              accept, skid_full;
  dsfp_pkg::result_t core_res, out_res;

  // Take a transfer whenever the skid stage has room.
  assign accept     = in_valid_i && !skid_full;
  assign in_stall_o = skid_full;

  // Advance pointers, counter and fill count; form the result for this item.
  dsfp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .func_i         (func_i),
    .sample_value_i (sample_value_i),
    .led_pattern_i  (led_pattern_i),
    .playing_i      (playing_i),
    .standby_i      (standby_i),
    .result_o       (core_res)
  );

  // Hold results until the downstream side takes them.
  dsfp_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .result_i    (core_res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign dac_valid_o     = out_res.dac_valid;
  assign dac_word_o      = out_res.dac_word;
  assign led_valid_o     = out_res.led_valid;
  assign led_value_o     = out_res.led_value;
  assign fill_level_o    = out_res.fill_level;
  assign push_accepted_o = out_res.push_accepted;

  // A full skid stage always sits behind a held output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid stage full without a valid output");

  // Every DAC word carries the command flag.
  a_dac_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dac_valid_o) |-> dac_word_o[12])
    else $error("DAC word without command flag");

  // A stored push never emits a DAC word or an LED update.
  a_push_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && push_accepted_o) |-> (!dac_valid_o && !led_valid_o))
    else $error("push result also carries tick output");

endmodule

### sim/tb.sv
// Self-checking testbench for dac_sample_fifo_pacer_top: random and directed transfers,
// checked against a scoreboard that tracks the FIFO, tick counter and rate register.
// Depends on dsfp_pkg and the RTL of the pacer top level.
module tb;
  import dsfp_pkg::*;

  // Spare function code: the block ignores it apart from reporting the fill level
  localparam logic [1:0] FuncSpare = 2'd3;
  localparam int unsigned ClkHalf = 4;
  localparam int unsigned LimitCycles = 400000;

  // Scoreboard: own copy of the sample store, positions, fill count and tick counter
  class pacer_scoreboard;
    logic [EntryW-1:0] sample_store [FifoDepth];
    logic [PtrW-1:0]   wr_pos;
    logic [PtrW-1:0]   rd_pos;
    int unsigned       fill_count;
    logic [TickW-1:0]  tick_count;
    logic [TickW-1:0]  reload_value;
    result_t           expected_q [$];
    int unsigned       mismatches;
    int unsigned       transfers;
    int unsigned       words_sent;
    int unsigned       leds_shown;
    int unsigned       pushes_dropped;

    function new();
      foreach (sample_store[i]) sample_store[i] = '0;
      wr_pos = '0;
      rd_pos = '0;
      fill_count = 0;
      tick_count = 8'd4;
      reload_value = 8'd4;
      mismatches = 0;
      transfers = 0;
      words_sent = 0;
      leds_shown = 0;
      pushes_dropped = 0;
    endfunction

    function void set_rate(logic [TickW-1:0] v);
      reload_value = v;
    endfunction

    function logic [PtrW-1:0] step_pos(logic [PtrW-1:0] p);
      if (int'(p) == FifoDepth - 1) begin
        return '0;
      end
      return p + 1'b1;
    endfunction

    // Work out the result of one accepted input transfer and queue it
    function void note_transfer(logic [1:0] f, logic [SampleW-1:0] s, logic [LedW-1:0] l,
                                logic p, logic sb);
      result_t r;
      r = '0;
      transfers++;
      case (f)
        FuncTick: begin
          tick_count = tick_count - 8'd1;
          if (p && !sb) begin
            if (tick_count == 8'd2) begin
              r.led_valid = 1'b1;
              r.led_value = sample_store[rd_pos][15:12];
              leds_shown++;
            end
            if (tick_count == 8'd0) begin
              tick_count = reload_value;
              if (fill_count != 0) begin
                r.dac_valid = 1'b1;
                r.dac_word = {4'b0001, sample_store[rd_pos][11:0]};
                rd_pos = step_pos(rd_pos);
                fill_count--;
                words_sent++;
              end
            end
          end
        end
        FuncPush: begin
          if (fill_count < FifoDepth) begin
            sample_store[wr_pos] = {l, s};
            wr_pos = step_pos(wr_pos);
            fill_count++;
            r.push_accepted = 1'b1;
          end else begin
            pushes_dropped++;
          end
        end
        FuncFlush: begin
          wr_pos = '0;
          rd_pos = '0;
          fill_count = 0;
        end
        default: ;
      endcase
      r.fill_level = fill_count[LevelW-1:0];
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no expectation waiting");
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("dac_valid", want.dac_valid, got.dac_valid);
      compare_field("dac_word", want.dac_word, got.dac_word);
      compare_field("led_valid", want.led_valid, got.led_valid);
      compare_field("led_value", want.led_value, got.led_value);
      compare_field("fill_level", want.fill_level, got.fill_level);
      compare_field("push_accepted", want.push_accepted, got.push_accepted);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [TickW-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          func_i = FuncTick;
  logic [SampleW-1:0]  sample_value_i = '0;
  logic [LedW-1:0]     led_pattern_i = '0;
  logic                playing_i = 1'b0;
  logic                standby_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                dac_valid_o;
  logic [EntryW-1:0]   dac_word_o;
  logic                led_valid_o;
  logic [LedW-1:0]     led_value_o;
  logic [LevelW-1:0]   fill_level_o;
  logic                push_accepted_o;

  pacer_scoreboard book = new();
  int unsigned send_idle_pct = 25;
  int unsigned recv_stall_pct = 25;
  int unsigned rate_writes = 0;

  dac_sample_fifo_pacer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .sample_value_i  (sample_value_i),
    .led_pattern_i   (led_pattern_i),
    .playing_i       (playing_i),
    .standby_i       (standby_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dac_valid_o     (dac_valid_o),
    .dac_word_o      (dac_word_o),
    .led_valid_o     (led_valid_o),
    .led_value_o     (led_value_o),
    .fill_level_o    (fill_level_o),
    .push_accepted_o (push_accepted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(2 * ClkHalf * LimitCycles);
    $display("tb failed");
    $finish;
  end

  // Result side: check every completed transfer, then pick the next stall at random.
  // Outputs are sampled at the edge, before the block's own updates land.
  initial begin
    result_t got;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.dac_valid = dac_valid_o;
        got.dac_word = dac_word_o;
        got.led_valid = led_valid_o;
        got.led_value = led_value_o;
        got.fill_level = fill_level_o;
        got.push_accepted = push_accepted_o;
        book.check_result(got);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Present one item and hold it until the transfer completes. Valid stays high on
  // return, so back-to-back items need no extra edge; the next call lowers it if idling.
  task automatic send_item(input logic [1:0] f, input logic [SampleW-1:0] s,
                           input logic [LedW-1:0] l, input logic p, input logic sb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    sample_value_i <= s;
    led_pattern_i <= l;
    playing_i <= p;
    standby_i <= sb;
    do @(posedge clk_i); while (in_stall_o);
    book.note_transfer(f, s, l, p, sb);
  endtask

  // Drop valid and hold off until every expected result has been collected
  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Rate changes only while the block is empty
  task automatic write_rate(input logic [TickW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    book.set_rate(v);
    cfg_we_i <= 1'b0;
    rate_writes++;
  endtask

  // Random traffic in segments: mixed, fill bursts that run into a full buffer and wrap
  // the write position, and drain runs that empty it. Spare codes do not count.
  task automatic run_random(input int unsigned count);
    int unsigned done;
    int unsigned seg_left;
    int unsigned mode;
    int unsigned roll;
    logic [1:0] f;
    done = 0;
    seg_left = 0;
    mode = 0;
    while (done < count) begin
      if (seg_left == 0) begin
        mode = $urandom_range(2);
        seg_left = $urandom_range(80, 20);
      end
      seg_left--;
      roll = $urandom_range(99);
      if (mode == 0) begin
        if (roll < 45) f = FuncTick;
        else if (roll < 90) f = FuncPush;
        else if (roll < 93) f = FuncFlush;
        else f = FuncSpare;
      end else if (mode == 1) begin
        if (roll < 88) f = FuncPush;
        else if (roll < 98) f = FuncTick;
        else f = FuncSpare;
      end else begin
        f = (roll < 95) ? FuncTick : FuncPush;
      end
      send_item(f, SampleW'($urandom), LedW'($urandom),
                $urandom_range(99) < 85, $urandom_range(99) < 12);
      if (f != FuncSpare) done++;
    end
  endtask

  initial begin
    logic [TickW-1:0] rates [8];
    rates = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd3, 8'd5, 8'd4, 8'd4};
    rates[6] = TickW'($urandom_range(16, 1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty buffer: count 2 shows the never-written head entry, count 0 reloads quietly
    repeat (4) send_item(FuncTick, '0, '0, 1'b1, 1'b0);
    // Extremes of sample and pattern
    send_item(FuncPush, 12'hfff, 4'hf, 1'b1, 1'b0);
    send_item(FuncPush, 12'h000, 4'h0, 1'b0, 1'b1);
    send_item(FuncPush, 12'haaa, 4'h5, 1'b1, 1'b0);
    send_item(FuncPush, 12'h555, 4'ha, 1'b1, 1'b0);
    // Spare code with every payload bit set: only the fill level comes back
    send_item(FuncSpare, 12'hfff, 4'hf, 1'b1, 1'b1);
    // Paced playback: pattern at count 2, word at count 0
    repeat (4) send_item(FuncTick, '0, '0, 1'b1, 1'b0);
    // Gated ticks: counter runs on and wraps past zero without reloading
    repeat (2) send_item(FuncTick, 12'hfff, 4'hf, 1'b0, 1'b0);
    repeat (3) send_item(FuncTick, '0, '0, 1'b1, 1'b1);
    send_item(FuncTick, '0, '0, 1'b0, 1'b1);
    // Flush keeps the stored entries; only positions and count clear
    send_item(FuncFlush, 12'hfff, 4'hf, 1'b1, 1'b1);
    send_item(FuncTick, '0, '0, 1'b1, 1'b0);
    send_item(FuncPush, 12'h123, 4'h9, 1'b1, 1'b0);
    send_item(FuncFlush, '0, '0, 1'b0, 1'b0);

    // One phase per rate setting; the third phase is a quiet stretch free of idling and stalls
    foreach (rates[i]) begin
      write_rate(rates[i]);
      send_idle_pct = (i == 2) ? 0 : 25;
      recv_stall_pct = (i == 2) ? 0 : 25;
      run_random(144);
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d transfers over %0d rate settings: %0d DAC words, %0d LED updates,",
             book.transfers, rate_writes, book.words_sent, book.leds_shown);
    $display("  %0d pushes dropped on a full buffer", book.pushes_dropped);
    if (book.mismatches == 0 && book.expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dsfp_pkg.sv
hw/rtl/dsfp_ram.sv
hw/rtl/dsfp_core.sv
hw/rtl/dsfp_out_skid.sv
hw/rtl/dac_sample_fifo_pacer_top.sv
sim/tb.sv
